// ----- src/pwmpps_pkg.sv -----
`timescale 1ns / 1ps

package pwmpps_pkg;

    // One requested period and active time, both in nanoseconds.
    typedef struct packed {
        logic [30:0] period_ns;
        logic [30:0] duty_ns;
    } in_beat_t;

    typedef struct packed {
        logic        solved;
        logic [3:0]  prescaler_code;
        logic [15:0] period_field;
        logic [15:0] duty_field;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_CHECK,
        ST_SCAN_NEXT,
        ST_DONE
    } state_t;

    // Which quotient the shared divider is producing.
    typedef enum logic [1:0] {
        OP_DIRECT,
        OP_RATE,
        OP_SCAN,
        OP_DUTY
    } op_t;

    localparam logic [30:0] NS_PER_SEC       = 31'd1000000000;
    localparam logic [63:0] HALF_NS          = 64'd500000000;
    localparam logic [31:0] CLOCK_RATE_RESET = 32'd24000000;
    localparam logic [3:0]  DIRECT_CODE      = 4'd15;
    localparam logic [3:0]  FIRST_SCAN_CODE  = 4'd0;
    localparam logic [3:0]  LAST_SCAN_CODE   = 4'd14;
    localparam logic [6:0]  DIV_LONG_STEPS   = 7'd64;
    localparam logic [6:0]  DIV_SHORT_STEPS  = 7'd32;
    localparam logic        REG_CLOCK_RATE   = 1'b0;

    // Clock divisor behind each prescaler code; zero marks an unused code.
    function automatic logic [16:0] code_divisor(input logic [3:0] code);
        logic [16:0] d;
        case (code)
            4'd0:    d = 17'd120;
            4'd1:    d = 17'd180;
            4'd2:    d = 17'd240;
            4'd3:    d = 17'd360;
            4'd4:    d = 17'd480;
            4'd8:    d = 17'd12000;
            4'd9:    d = 17'd24000;
            4'd10:   d = 17'd36000;
            4'd11:   d = 17'd48000;
            4'd12:   d = 17'd72000;
            default: d = 17'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- src/pwm_prescaler_period_solver_unit.sv -----
`timescale 1ns / 1ps

// Solves a requested PWM period and active time (in nanoseconds) into a prescaler code, a
// period field (count minus one) and a duty field for a COUNTER_WIDTH-bit PWM counter, using
// the clock rate held in the register at byte address 0. One multiplier and one radix-2
// divider that yields a quotient bit per cycle do all the arithmetic, so a request is worked
// on alone and the input stalls until its result has been handed to the output register.
// A request that fits with the clock divided by one is solved directly; otherwise each used
// prescaler code is tried in turn with a 32-step divide for the scaled clock and a 64-step
// divide for the count, skipping unused codes, until one fits or the last code has failed.
module pwm_prescaler_period_solver_unit #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  pwmpps_pkg::in_beat_t   in_beat,

    output logic                   out_valid,
    input  logic                   out_stall,
    output pwmpps_pkg::out_beat_t  out_beat,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    import pwmpps_pkg::*;

    localparam int CNT_W  = COUNTER_WIDTH + 1;
    localparam int MUL_AW = (CNT_W > 32) ? CNT_W : 32;
    localparam logic [63:0] COUNT_MAX = 64'd1 << COUNTER_WIDTH;
    localparam logic [63:0] ACT_MASK  = COUNT_MAX - 64'd1;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [3:0]        code_reg, code_next;
    logic              solved_reg, solved_next;
    logic [31:0]       clock_rate_reg, clock_rate_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_reg, out_next;

    logic [30:0]       period_reg, period_next;
    logic [30:0]       duty_reg, duty_next;
    logic [63:0]       prod_reg, prod_next;
    logic [63:0]       quo_reg, quo_next;
    logic [30:0]       rem_reg, rem_next;
    logic [30:0]       den_reg, den_next;
    logic [6:0]        iter_reg, iter_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       scaled_reg, scaled_next;

    logic [MUL_AW-1:0] mul_a;
    logic [30:0]       mul_b;
    logic [MUL_AW+30:0] mul_p;
    logic [31:0]       rem_sh;
    logic [32:0]       diff;
    logic              fits;
    logic              div_last;
    logic              code_unused;
    logic              out_free;
    logic              cfg_wr;
    logic [63:0]       count_m1;
    logic [63:0]       active;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_CLOCK_RATE) ? clock_rate_reg : 32'd0;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_CLOCK_RATE);

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (op_reg)
            OP_DUTY: mul_a = MUL_AW'(count_reg);
            OP_SCAN: mul_a = MUL_AW'(scaled_reg);
            default: mul_a = MUL_AW'(clock_rate_reg);
        endcase
        mul_b = (op_reg == OP_DUTY) ? duty_reg : period_reg;
    end
    assign mul_p = mul_a * mul_b;

    // One step of restoring division: shift in the next dividend bit and try the subtract.
    assign rem_sh   = {rem_reg, quo_reg[63]};
    assign diff     = {1'b0, rem_sh} - {2'b00, den_reg};
    assign div_last = (iter_reg == 7'd1);

    assign fits        = (quo_reg != 64'd0) && (quo_reg <= COUNT_MAX);
    assign code_unused = (code_divisor(code_reg) == 17'd0);
    assign count_m1    = 64'(count_reg) - 64'd1;
    assign active      = quo_reg & ACT_MASK;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_last)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                unique case (op_reg)
                    OP_DIRECT: state_next = fits ? ST_MUL : ST_SCAN_NEXT;
                    OP_RATE:   state_next = ST_MUL;
                    OP_SCAN:
                    begin
                        if (fits)
                            state_next = ST_MUL;
                        else if (code_reg == LAST_SCAN_CODE)
                            state_next = ST_DONE;
                        else
                            state_next = ST_SCAN_NEXT;
                    end
                    OP_DUTY:   state_next = ST_DONE;
                endcase
            end
            ST_SCAN_NEXT:
            begin
                if (!code_unused)
                    state_next = ST_LOAD;
                else if (code_reg == LAST_SCAN_CODE)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        code_next       = code_reg;
        solved_next     = solved_reg;
        clock_rate_next = cfg_wr ? pwdata : clock_rate_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        period_next     = period_reg;
        duty_next       = duty_reg;
        prod_next       = prod_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        iter_next       = iter_reg;
        count_next      = count_reg;
        scaled_next     = scaled_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    period_next = in_beat.period_ns;
                    duty_next   = in_beat.duty_ns;
                    op_next     = OP_DIRECT;
                    solved_next = 1'b0;
                end
            end
            ST_MUL:
            begin
                prod_next = 64'(mul_p);
            end
            ST_LOAD:
            begin
                rem_next = 31'd0;
                unique case (op_reg)
                    OP_DIRECT:
                    begin
                        quo_next  = prod_reg + HALF_NS;
                        den_next  = NS_PER_SEC;
                        iter_next = DIV_LONG_STEPS;
                    end
                    OP_RATE:
                    begin
                        // A 32-bit dividend sits in the upper half so 32 steps suffice.
                        quo_next  = {clock_rate_reg, 32'd0};
                        den_next  = 31'(code_divisor(code_reg));
                        iter_next = DIV_SHORT_STEPS;
                    end
                    OP_SCAN:
                    begin
                        quo_next  = prod_reg;
                        den_next  = NS_PER_SEC;
                        iter_next = DIV_LONG_STEPS;
                    end
                    OP_DUTY:
                    begin
                        quo_next  = prod_reg;
                        den_next  = period_reg;
                        iter_next = DIV_LONG_STEPS;
                    end
                endcase
            end
            ST_DIV:
            begin
                quo_next  = {quo_reg[62:0], ~diff[32]};
                rem_next  = diff[32] ? rem_sh[30:0] : diff[30:0];
                iter_next = iter_reg - 7'd1;
            end
            ST_CHECK:
            begin
                unique case (op_reg)
                    OP_DIRECT:
                    begin
                        if (fits)
                        begin
                            count_next  = quo_reg[CNT_W-1:0];
                            code_next   = DIRECT_CODE;
                            solved_next = 1'b1;
                            op_next     = OP_DUTY;
                        end
                        else
                            code_next = FIRST_SCAN_CODE;
                    end
                    OP_RATE:
                    begin
                        scaled_next = quo_reg[31:0];
                        op_next     = OP_SCAN;
                    end
                    OP_SCAN:
                    begin
                        if (fits)
                        begin
                            count_next  = quo_reg[CNT_W-1:0];
                            solved_next = 1'b1;
                            op_next     = OP_DUTY;
                        end
                        else if (code_reg != LAST_SCAN_CODE)
                            code_next = code_reg + 4'd1;
                    end
                    OP_DUTY:
                    begin
                        op_next = OP_DUTY;
                    end
                endcase
            end
            ST_SCAN_NEXT:
            begin
                if (!code_unused)
                    op_next = OP_RATE;
                else if (code_reg != LAST_SCAN_CODE)
                    code_next = code_reg + 4'd1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (solved_reg)
                    begin
                        out_next.solved         = 1'b1;
                        out_next.prescaler_code = code_reg;
                        out_next.period_field   = count_m1[15:0];
                        out_next.duty_field     = active[15:0];
                    end
                    else
                    begin
                        out_next.solved         = 1'b0;
                        out_next.prescaler_code = 4'd0;
                        out_next.period_field   = 16'd0;
                        out_next.duty_field     = 16'd0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_DIRECT;
            code_reg       <= FIRST_SCAN_CODE;
            solved_reg     <= 1'b0;
            clock_rate_reg <= CLOCK_RATE_RESET;
            out_valid_reg  <= 1'b0;
            iter_reg       <= 7'd0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            code_reg       <= code_next;
            solved_reg     <= solved_next;
            clock_rate_reg <= clock_rate_next;
            out_valid_reg  <= out_valid_next;
            iter_reg       <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        period_reg <= period_next;
        duty_reg   <= duty_next;
        prod_reg   <= prod_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        count_reg  <= count_next;
        scaled_reg <= scaled_next;
    end

endmodule
